[sv/gwr_pkg.sv]
// ----------------------------------------------------------------------------
// gwr_pkg: shared types and constants of the grid wavefront path router
// Beat formats, command, tile and distance codes, and the offset tables
// used to walk the neighbours of a cell.
// ----------------------------------------------------------------------------
package gwr_pkg;

	localparam int CELL_W = 6;
	localparam int DIM_W  = 7;
	localparam int DIST_W = 13;
	localparam int BEST_W = 15;
	localparam int LEN_W  = 12;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_ROUTE = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [2:0] KIND_WALL  = 3'd0;
	localparam logic [2:0] KIND_PATH  = 3'd1;
	localparam logic [2:0] KIND_FLOOR = 3'd2;
	localparam logic [2:0] KIND_DOOR  = 3'd3;
	localparam logic [2:0] KIND_OTHER = 3'd5;

	localparam logic [1:0] MARK_NONE  = 2'd0;
	localparam logic [1:0] MARK_OLD   = 2'd1;
	localparam logic [1:0] MARK_START = 2'd2;
	localparam logic [1:0] MARK_END   = 2'd3;

	localparam logic [DIST_W-1:0] D_FREE   = 13'h1FFF;
	localparam logic [DIST_W-1:0] D_BLOCK  = 13'h1FFE;
	localparam logic [DIST_W-1:0] D_TRACED = 13'h1FFD;

	localparam logic signed [BEST_W-1:0] NO_PICK = 15'sd10000;

	localparam logic       REG_GRID_WIDTH   = 1'b0;
	localparam logic       REG_GRID_HEIGHT  = 1'b1;
	localparam logic [2:0] ADDR_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_GRID_HEIGHT = 3'd4;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [2:0]        tile_kind;
		logic [1:0]        tile_mark;
		logic [CELL_W-1:0] end_x;
		logic [CELL_W-1:0] end_y;
	} req_t;

	typedef struct packed {
		logic [2:0]       read_kind;
		logic [1:0]       read_mark;
		logic [LEN_W-1:0] path_length;
	} rsp_t;

	typedef struct packed {
		logic [DIM_W-1:0] grid_width;
		logic [DIM_W-1:0] grid_height;
	} cfg_t;

	// 3x3 sweep step 0..8 -> {oy, ox}, each 0..2 standing for -1..+1
	function automatic logic [3:0] sq_offset(input logic [3:0] s);
		logic [3:0] r;
		case (s)
			4'd0:    r = {2'd0, 2'd0};
			4'd1:    r = {2'd0, 2'd1};
			4'd2:    r = {2'd0, 2'd2};
			4'd3:    r = {2'd1, 2'd0};
			4'd4:    r = {2'd1, 2'd1};
			4'd5:    r = {2'd1, 2'd2};
			4'd6:    r = {2'd2, 2'd0};
			4'd7:    r = {2'd2, 2'd1};
			4'd8:    r = {2'd2, 2'd2};
			default: r = {2'd1, 2'd1};
		endcase
		return r;
	endfunction

	// four-neighbour order: down, up, right, left
	function automatic logic [3:0] nb_offset(input logic [1:0] k);
		logic [3:0] r;
		case (k)
			2'd0:    r = {2'd2, 2'd1};
			2'd1:    r = {2'd0, 2'd1};
			2'd2:    r = {2'd1, 2'd2};
			default: r = {2'd1, 2'd0};
		endcase
		return r;
	endfunction

endpackage

[sv/gwr_cfg.sv]
// ----------------------------------------------------------------------------
// gwr_cfg: configuration registers
// APB-style register file holding the grid width and height in use.
// ----------------------------------------------------------------------------
module gwr_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output gwr_pkg::cfg_t     cfg
);

	logic [gwr_pkg::DIM_W-1:0] width_q;
	logic [gwr_pkg::DIM_W-1:0] height_q;
	logic [gwr_pkg::DIM_W-1:0] rd_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gwr_pkg::DIM_RESET;
			height_q <= gwr_pkg::DIM_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				gwr_pkg::REG_GRID_WIDTH:  width_q  <= pwdata[gwr_pkg::DIM_W-1:0];
				gwr_pkg::REG_GRID_HEIGHT: height_q <= pwdata[gwr_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			gwr_pkg::REG_GRID_WIDTH:  rd_val = width_q;
			gwr_pkg::REG_GRID_HEIGHT: rd_val = height_q;
			default:                  rd_val = width_q;
		endcase
	end

	// misaligned reads return zero
	assign prdata = (paddr[1:0] == 2'd0) ? {25'd0, rd_val} : 32'd0;
	assign pready = 1'b1;
	assign cfg    = '{grid_width: width_q, grid_height: height_q};

endmodule

[sv/grid_wavefront_path_router_core.sv]
// ----------------------------------------------------------------------------
// grid_wavefront_path_router_core: tile grid with maze router
// Tile grid written and read by command beats; a route beat floods a
// breadth-first wave from the start cell and draws a path to the end cell.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tile memory to wall tiles, one entry a
// cycle, over all MAX_WIDTH*MAX_HEIGHT entries (4096 at the defaults) with
// req_stall high. Tile write and read beats are then taken one per cycle
// while rsp is not stalled; a result is staged in v_s1, then registered on
// rsp, and every command beat gives exactly one rsp beat. A route beat
// holds the block busy: it labels each cell in use from its 3x3 neighbourhood
// (one read per cycle on the tile memory port), then per wave level scans
// all cells with a distance memory read-modify-write per neighbour of each
// wave front cell, traces the path back, paints the w*h cells, then gives
// the result. All route time is set by the single port of each memory.
// ----------------------------------------------------------------------------
module grid_wavefront_path_router_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  gwr_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output gwr_pkg::rsp_t   rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int LGW   = $clog2(MAX_WIDTH);
	localparam int LGH   = $clog2(MAX_HEIGHT);
	localparam int LGM   = (LGW > LGH) ? LGW : LGH;
	// coordinate width: room for the 6-bit fields and one step past the edge
	localparam int CW    = ((LGM > gwr_pkg::CELL_W) ? LGM : gwr_pkg::CELL_W) + 1;
	localparam int PW    = CW + WW;
	localparam int WHP   = WW + HW;
	localparam int SW    = AW + 1;
	localparam int DW    = gwr_pkg::DIST_W + 1;

	typedef enum logic [16:0] {
		ST_CLEAR  = 17'h00001,
		ST_IDLE   = 17'h00002,
		ST_INIT   = 17'h00004,
		ST_WRD    = 17'h00008,
		ST_WCHK   = 17'h00010,
		ST_NRD    = 17'h00020,
		ST_NWR    = 17'h00040,
		ST_BMARK  = 17'h00080,
		ST_BRD    = 17'h00100,
		ST_BEV    = 17'h00200,
		ST_BDEC   = 17'h00400,
		ST_PAINT  = 17'h00800,
		ST_PDRAIN = 17'h01000,
		ST_DOORA  = 17'h02000,
		ST_DOORB  = 17'h04000,
		ST_DONE   = 17'h08000,
		ST_HOLD   = 17'h10000
	} state_t;

	gwr_pkg::cfg_t cfg;

	gwr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------- sizes
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	// zero acts as one, values past the maximum clamp to it
	always_comb begin
		if (cfg.grid_width == '0) begin
			w_eff = WW'(1);
		end else if (int'(cfg.grid_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.grid_width);
		end
		if (cfg.grid_height == '0) begin
			h_eff = HW'(1);
		end else if (int'(cfg.grid_height) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg.grid_height);
		end
	end

	logic [CW-1:0] w_c, h_c;
	assign w_c = CW'(w_eff);
	assign h_c = CW'(h_eff);

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
			input logic [CW-1:0] y, input logic [WW-1:0] w);
		logic [PW-1:0] prod;
		prod = PW'(y) * PW'(w);
		return AW'(prod) + AW'(x);
	endfunction

	// ---------------------------------------------------------------- state
	state_t state_q;

	logic [AW-1:0]              clr_q;
	logic                       v_s1;
	logic [1:0]                 cmd_s1;
	logic                       on_s1;
	logic [4:0]                 trd_q;
	logic [DW-1:0]              drd_q;
	logic [CW-1:0]              ax_q, ay_q, bx_q, by_q;
	logic [CW-1:0]              ci_q, cj_q;
	logic [CW-1:0]              px_q, py_q, cx_q, cy_q;
	logic [3:0]                 s_q;
	logic [1:0]                 k_q;
	logic                       ok_q, free_q, nbon_s1, cen_s1;
	logic [gwr_pkg::DIST_W-1:0] move_q;
	logic                       any_q;
	logic signed [gwr_pkg::BEST_W-1:0] best_q;
	logic [SW-1:0]              steps_q;
	logic [AW-1:0]              lin_q;
	logic                       pv_s1;
	logic [AW-1:0]              pa_s1;
	logic [SW-1:0]              wh_q;
	gwr_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;

	// ---------------------------------------------------------------- handshake
	logic rsp_free, acc;
	logic [CW-1:0] rx, ry, rex, rey;
	logic req_on, end_on;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && (!v_s1 || rsp_free));
	assign acc       = req_valid && !req_stall;

	assign rx     = CW'(req.cell_x);
	assign ry     = CW'(req.cell_y);
	assign rex    = CW'(req.end_x);
	assign rey    = CW'(req.end_y);
	assign req_on = (rx < w_c) && (ry < h_c);
	assign end_on = (rex < w_c) && (rey < h_c);

	// ---------------------------------------------------------------- neighbour
	logic [CW-1:0] base_x, base_y, nx, ny;
	logic [3:0]    off;
	logic          nb_on;

	always_comb begin
		if (state_q == ST_BMARK || state_q == ST_BRD || state_q == ST_BEV) begin
			base_x = px_q;
			base_y = py_q;
		end else begin
			base_x = ci_q;
			base_y = cj_q;
		end
		off = (state_q == ST_INIT) ? gwr_pkg::sq_offset(s_q) : gwr_pkg::nb_offset(k_q);
	end

	assign nx    = base_x + CW'(off[1:0]) - CW'(1);
	assign ny    = base_y + CW'(off[3:2]) - CW'(1);
	assign nb_on = !(off[1:0] == 2'd0 && base_x == '0) &&
	               !(off[3:2] == 2'd0 && base_y == '0) &&
	               (nx < w_c) && (ny < h_c);

	// ---------------------------------------------------------------- decode
	logic [gwr_pkg::DIST_W-1:0] d_rd;
	logic                       ok_now, at_start, last_col, last_row, goal, bt_skip;
	logic [WHP-1:0]             wh_full;
	logic [2:0]                 kind_wr;

	assign d_rd     = drd_q[gwr_pkg::DIST_W-1:0];
	assign ok_now   = ok_q && nbon_s1 && (trd_q[4:2] != gwr_pkg::KIND_FLOOR);
	assign at_start = (ci_q == ax_q) && (cj_q == ay_q);
	assign last_col = (ci_q == w_c - CW'(1));
	assign last_row = (cj_q == h_c - CW'(1));
	assign goal     = ((ci_q == bx_q) && ((cj_q + CW'(1) == by_q) || (by_q + CW'(1) == cj_q))) ||
	                  ((cj_q == by_q) && ((ci_q + CW'(1) == bx_q) || (bx_q + CW'(1) == ci_q)));
	// drop labels at or above the traced code: traced, blocked, free
	assign bt_skip  = (d_rd >= gwr_pkg::D_TRACED);
	assign wh_full  = WHP'(w_eff) * WHP'(h_eff);
	assign kind_wr  = (req.tile_kind > gwr_pkg::KIND_OTHER) ? gwr_pkg::KIND_OTHER : req.tile_kind;

	// ---------------------------------------------------------------- memory ports
	logic          t_we, t_re, d_we, d_re;
	logic [CW-1:0] tx, ty, dx, dy;
	logic [AW-1:0] t_addr, d_addr;
	logic [4:0]    t_wdata;
	logic [DW-1:0] d_wdata;

	always_comb begin
		t_we    = 1'b0;
		t_re    = 1'b0;
		t_wdata = {gwr_pkg::KIND_WALL, gwr_pkg::MARK_NONE};
		tx      = nx;
		ty      = ny;
		d_we    = 1'b0;
		d_re    = 1'b0;
		d_wdata = {1'b0, gwr_pkg::D_TRACED};
		dx      = ci_q;
		dy      = cj_q;
		case (state_q)
			ST_IDLE: begin
				tx      = rx;
				ty      = ry;
				t_we    = acc && (req.cmd == gwr_pkg::CMD_WRITE) && req_on;
				t_re    = acc && (req.cmd == gwr_pkg::CMD_READ);
				t_wdata = {kind_wr, req.tile_mark};
			end
			ST_CLEAR: t_we = 1'b1;
			ST_INIT: begin
				t_re    = (s_q != 4'd9);
				d_we    = (s_q == 4'd9);
				d_wdata = {ok_now, at_start ? gwr_pkg::DIST_W'(0) :
				           (free_q ? gwr_pkg::D_FREE : gwr_pkg::D_BLOCK)};
			end
			ST_WRD:  d_re = 1'b1;
			ST_NRD: begin
				dx   = nx;
				dy   = ny;
				d_re = nb_on;
			end
			ST_NWR: begin
				dx      = nx;
				dy      = ny;
				d_we    = drd_q[gwr_pkg::DIST_W] && (d_rd == gwr_pkg::D_FREE);
				d_wdata = {1'b1, move_q + gwr_pkg::DIST_W'(1)};
			end
			ST_BMARK: begin
				dx   = px_q;
				dy   = py_q;
				d_we = 1'b1;
			end
			ST_BRD: begin
				dx   = nx;
				dy   = ny;
				d_re = nb_on;
				t_re = nb_on;
			end
			ST_PAINT: begin
				d_re    = 1'b1;
				t_we    = pv_s1 && (d_rd == gwr_pkg::D_TRACED);
				t_wdata = {gwr_pkg::KIND_PATH, gwr_pkg::MARK_OLD};
			end
			ST_PDRAIN: begin
				t_we    = pv_s1 && (d_rd == gwr_pkg::D_TRACED);
				t_wdata = {gwr_pkg::KIND_PATH, gwr_pkg::MARK_OLD};
			end
			ST_DOORA: begin
				tx      = ax_q;
				ty      = ay_q;
				t_we    = 1'b1;
				t_wdata = {gwr_pkg::KIND_DOOR, gwr_pkg::MARK_START};
			end
			ST_DOORB: begin
				tx      = bx_q;
				ty      = by_q;
				t_we    = 1'b1;
				t_wdata = {gwr_pkg::KIND_DOOR, gwr_pkg::MARK_END};
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			t_addr = clr_q;
		end else if (state_q == ST_PAINT || state_q == ST_PDRAIN) begin
			t_addr = pa_s1;
		end else begin
			t_addr = cell_addr(tx, ty, w_eff);
		end
		d_addr = (state_q == ST_PAINT) ? lin_q : cell_addr(dx, dy, w_eff);
	end

	// tile kind and mark per cell
	logic [4:0] tile_mem [CELLS];

	always_ff @(posedge clk) begin
		if (t_we) begin
			tile_mem[t_addr] <= t_wdata;
		end
		if (t_re) begin
			trd_q <= tile_mem[t_addr];
		end
	end

	// entry flag and wave label per cell
	logic [DW-1:0] dist_mem [CELLS];

	always_ff @(posedge clk) begin
		if (d_we) begin
			dist_mem[d_addr] <= d_wdata;
		end
		if (d_re) begin
			drd_q <= dist_mem[d_addr];
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ax_q    <= '0;
			ay_q    <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			ci_q    <= '0;
			cj_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			s_q     <= '0;
			k_q     <= '0;
			ok_q    <= 1'b0;
			free_q  <= 1'b0;
			nbon_s1 <= 1'b0;
			cen_s1  <= 1'b0;
			move_q  <= '0;
			any_q   <= 1'b0;
			best_q  <= gwr_pkg::NO_PICK;
			steps_q <= '0;
			lin_q   <= '0;
			pv_s1   <= 1'b0;
			pa_s1   <= '0;
			wh_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc && req.cmd == gwr_pkg::CMD_ROUTE) begin
						ax_q    <= rx;
						ay_q    <= ry;
						bx_q    <= rex;
						by_q    <= rey;
						ci_q    <= '0;
						cj_q    <= '0;
						s_q     <= '0;
						steps_q <= '0;
						wh_q    <= SW'(wh_full);
						// off-map endpoint: answer zero, touch nothing
						state_q <= (req_on && end_on) ? ST_INIT : ST_DONE;
					end
				end
				ST_INIT: begin
					// one neighbourhood read per step, data checked a step later
					if (s_q != 4'd9) begin
						nbon_s1 <= nb_on;
						cen_s1  <= (s_q == 4'd4);
					end
					if (s_q == 4'd0) begin
						ok_q <= 1'b1;
					end else begin
						ok_q <= ok_now;
						if (cen_s1) begin
							free_q <= (trd_q[4:2] == gwr_pkg::KIND_WALL) ||
							          (trd_q[4:2] == gwr_pkg::KIND_PATH);
						end
					end
					if (s_q == 4'd9) begin
						s_q <= '0;
						if (last_col) begin
							ci_q <= '0;
							if (last_row) begin
								cj_q    <= '0;
								move_q  <= '0;
								any_q   <= 1'b0;
								state_q <= ST_WRD;
							end else begin
								cj_q <= cj_q + CW'(1);
							end
						end else begin
							ci_q <= ci_q + CW'(1);
						end
					end else begin
						s_q <= s_q + 4'd1;
					end
				end
				ST_WRD: state_q <= ST_WCHK;
				ST_WCHK: begin
					if (d_rd != move_q) begin
						state_q <= ST_HOLD;
					end else if (goal) begin
						px_q    <= bx_q;
						py_q    <= by_q;
						state_q <= ST_BMARK;
					end else begin
						k_q     <= '0;
						state_q <= ST_NRD;
					end
				end
				ST_NRD: begin
					if (nb_on) begin
						state_q <= ST_NWR;
					end else if (k_q == 2'd3) begin
						state_q <= ST_HOLD;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_NWR: begin
					if (d_we) begin
						any_q <= 1'b1;
					end
					if (k_q == 2'd3) begin
						state_q <= ST_HOLD;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_NRD;
					end
				end
				ST_HOLD: begin
					// advance the raster scan; a pass with no new label ends the wave
					if (last_col) begin
						ci_q <= '0;
						if (last_row) begin
							cj_q <= '0;
							if (any_q) begin
								move_q  <= move_q + gwr_pkg::DIST_W'(1);
								any_q   <= 1'b0;
								state_q <= ST_WRD;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							cj_q    <= cj_q + CW'(1);
							state_q <= ST_WRD;
						end
					end else begin
						ci_q    <= ci_q + CW'(1);
						state_q <= ST_WRD;
					end
				end
				ST_BMARK: begin
					k_q     <= '0;
					best_q  <= gwr_pkg::NO_PICK;
					state_q <= ST_BRD;
				end
				ST_BRD: begin
					if (nb_on) begin
						state_q <= ST_BEV;
					end else if (k_q == 2'd3) begin
						state_q <= ST_BDEC;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_BEV: begin
					// an equal or lower label wins over a plain cell, old path cells count two less
					if (!bt_skip && $signed({2'b00, d_rd}) < best_q) begin
						cx_q   <= nx;
						cy_q   <= ny;
						best_q <= (trd_q[1:0] == gwr_pkg::MARK_OLD) ?
						          $signed({2'b00, d_rd}) - 15'sd1 :
						          $signed({2'b00, d_rd}) + 15'sd1;
					end
					if (k_q == 2'd3) begin
						state_q <= ST_BDEC;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_BRD;
					end
				end
				ST_BDEC: begin
					lin_q <= '0;
					pv_s1 <= 1'b0;
					if (best_q == gwr_pkg::NO_PICK) begin
						state_q <= (steps_q != '0) ? ST_PAINT : ST_DONE;
					end else begin
						steps_q <= steps_q + SW'(1);
						px_q    <= cx_q;
						py_q    <= cy_q;
						state_q <= (cx_q == ax_q && cy_q == ay_q) ? ST_PAINT : ST_BMARK;
					end
				end
				ST_PAINT: begin
					pv_s1 <= 1'b1;
					pa_s1 <= lin_q;
					if (SW'(lin_q) == wh_q - SW'(1)) begin
						state_q <= ST_PDRAIN;
					end else begin
						lin_q <= lin_q + AW'(1);
					end
				end
				ST_PDRAIN: begin
					pv_s1   <= 1'b0;
					state_q <= ST_DOORA;
				end
				ST_DOORA: state_q <= ST_DOORB;
				ST_DOORB: state_q <= ST_DONE;
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			cmd_s1      <= gwr_pkg::CMD_NOP;
			on_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// hold the tile beat in v_s1 while its read data lands
			if (acc && req.cmd != gwr_pkg::CMD_ROUTE) begin
				v_s1   <= 1'b1;
				cmd_s1 <= req.cmd;
				on_s1  <= req_on;
			end else if (rsp_free) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && rsp_free) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.path_length <= '0;
				if (cmd_s1 == gwr_pkg::CMD_READ) begin
					rsp_q.read_kind <= on_s1 ? trd_q[4:2] : gwr_pkg::KIND_OTHER;
					rsp_q.read_mark <= on_s1 ? trd_q[1:0] : gwr_pkg::MARK_NONE;
				end else begin
					rsp_q.read_kind <= gwr_pkg::KIND_WALL;
					rsp_q.read_mark <= gwr_pkg::MARK_NONE;
				end
			end else if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.read_kind   <= gwr_pkg::KIND_WALL;
				rsp_q.read_mark   <= gwr_pkg::MARK_NONE;
				rsp_q.path_length <= gwr_pkg::LEN_W'(steps_q);
			end else if (rsp_free) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/gwr_core_chk.sv]
// ----------------------------------------------------------------------------
// gwr_core_chk: port checker for the path router core
// Watches the command, result and register ports over time.
// ----------------------------------------------------------------------------
module gwr_core_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input gwr_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input gwr_pkg::rsp_t rsp,
	input logic          psel,
	input logic          penable,
	input logic          pwrite,
	input logic [2:0]    paddr,
	input logic [31:0]   pwdata,
	input logic [31:0]   prdata,
	input logic          pready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("result beat changed while stalled");

	// a route keeps the block busy, so no beat follows it at once
	a_route_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.cmd == gwr_pkg::CMD_ROUTE |=> req_stall)
		else $error("beat taken right after a route beat");

	a_cfg_back: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == gwr_pkg::ADDR_GRID_WIDTH) ##1
		(psel && penable && !pwrite && paddr == gwr_pkg::ADDR_GRID_WIDTH)
		|-> prdata[6:0] == $past(pwdata[6:0]))
		else $error("grid width read back differs from last write");

endmodule

bind grid_wavefront_path_router_core gwr_core_chk u_gwr_core_chk (.*);
